/* hw/rtl/hrg_pkg.sv */
package hrg_pkg;

    // Parameter defaults
    localparam int LUT_DEPTH_DEF = 256;
    localparam int OUT_BITS_DEF  = 16;

    // Item codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Channel codes
    localparam int N_CH = 3;
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Hue sectors, 60 degrees each
    localparam logic [2:0] SEC_R_TO_Y = 3'd0;
    localparam logic [2:0] SEC_Y_TO_G = 3'd1;
    localparam logic [2:0] SEC_G_TO_C = 3'd2;
    localparam logic [2:0] SEC_C_TO_B = 3'd3;
    localparam logic [2:0] SEC_B_TO_M = 3'd4;
    localparam logic [2:0] SEC_M_TO_R = 3'd5;
    localparam int N_SEC = 6;

    // Fixed-point scale: hue in 1/64 degree, levels 0..255
    localparam int LEVELS     = 256;
    localparam int LEVEL_MAX  = 255;
    localparam int HUE_CIRCLE = 23040;
    localparam int HUE_SECTOR = 3840;
    localparam int FRAC_ONE   = 979200;   // 255 * 3840
    localparam int FRAC_HALF  = 489600;

    // x / 255 = (x * 32897) >> 23, exact for 16-bit x
    localparam int DIV255_MUL = 32897;
    localparam int DIV255_SH  = 23;
    // Level quotient: (z >> 8) / 3825, estimate (x * 4386) >> 24 is q or q-1
    localparam int LVL_DIV     = 3825;
    localparam int LVL_DIV_MUL = 4386;
    localparam int LVL_DIV_SH  = 24;

    // Read/write strobes for one gamma lane
    typedef struct packed {
        logic we;
        logic re;
    } t_lane_ctl;

    // Item leaving the level pipeline
    typedef struct packed {
        logic                  valid;
        logic                  wr;
        logic [1:0]            ch;
        logic [7:0]            tidx;
        logic [15:0]           ent;
        logic [N_CH-1:0][7:0]  lvl;
    } t_lvl;

endpackage

/* hw/rtl/hrg_ifs.sv */
interface hrg_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic [1:0]  table_channel;
    logic [7:0]  table_index;
    logic [15:0] table_entry;

    modport source (
        output valid, operation, hue, saturation, brightness,
               table_channel, table_index, table_entry,
        input  ready
    );
    modport sink (
        input  valid, operation, hue, saturation, brightness,
               table_channel, table_index, table_entry,
        output ready
    );
endinterface

interface hrg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue,
        output ready
    );
endinterface

/* hw/rtl/hrg_level.sv */
module hrg_level (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hrg_in_if.sink       i_in,
    input  logic         i_take,
    output hrg_pkg::t_lvl o_lvl
);
    import hrg_pkg::*;

    localparam int NST = 7;

    // fields that ride along every stage
    typedef struct packed {
        logic        wr;
        logic [1:0]  ch;
        logic [7:0]  tidx;
        logic [15:0] ent;
        logic [7:0]  s;
        logic [7:0]  v;
    } t_item;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    t_item          r_it [NST];

    logic [15:0] r0_hue;
    logic [14:0] r1_hm;
    logic [2:0]  r2_sec;
    logic [11:0] r2_rem;
    logic [15:0] r2_pn;
    logic [2:0]  r3_sec;
    logic [19:0] r3_sr;
    logic [19:0] r3_st;
    logic [7:0]  r3_p;
    logic [2:0]  r4_sec;
    logic [7:0]  r4_p;
    logic [19:0] r4_xq;
    logic [19:0] r4_xt;
    logic [2:0]  r5_sec;
    logic [7:0]  r5_p;
    logic [19:0] r5_xq;
    logic [19:0] r5_xt;
    logic [7:0]  r5_q0;
    logic [7:0]  r5_t0;
    logic [N_CH-1:0][7:0] r6_lvl;

    logic [14:0] n_hm;
    logic [2:0]  n_sec;
    logic [11:0] n_rem;
    logic [15:0] n_pn;
    logic [19:0] n_sr;
    logic [19:0] n_st;
    logic [32:0] w_pprod;
    logic [7:0]  n_p;
    logic [27:0] w_zq;
    logic [27:0] w_zt;
    logic [31:0] w_qprod;
    logic [31:0] w_tprod;
    logic [19:0] w_remq;
    logic [19:0] w_remt;
    logic [7:0]  w_q;
    logic [7:0]  w_t;
    logic [N_CH-1:0][7:0] n_lvl;

    // stage advances when empty or when the next one advances
    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_take;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0 -> 1: hue modulo a full circle
    always_comb begin
        if (r0_hue >= 16'(2 * HUE_CIRCLE)) begin
            n_hm = 15'(r0_hue - 16'(2 * HUE_CIRCLE));
        end else if (r0_hue >= 16'(HUE_CIRCLE)) begin
            n_hm = 15'(r0_hue - 16'(HUE_CIRCLE));
        end else begin
            n_hm = 15'(r0_hue);
        end
    end

    // stage 1 -> 2: sector, remainder within it, p numerator
    always_comb begin
        n_sec = SEC_R_TO_Y;
        for (int k = 1; k < N_SEC; k++) begin
            if (r1_hm >= 15'(k * HUE_SECTOR)) begin
                n_sec = 3'(k);
            end
        end
        n_rem = 12'(r1_hm - 15'(n_sec) * 15'(HUE_SECTOR));
        n_pn  = 16'(16'(r_it[1].v) * (16'(LEVEL_MAX) - 16'(r_it[1].s)))
                + 16'(LEVEL_MAX / 2);
    end

    // stage 2 -> 3: s*r, s*(1-r), p = pn / 255
    assign n_sr    = 20'(r_it[2].s) * 20'(r2_rem);
    assign n_st    = 20'(r_it[2].s) * 20'(12'(HUE_SECTOR) - r2_rem);
    assign w_pprod = 33'(r2_pn) * 33'(DIV255_MUL);
    assign n_p     = w_pprod[DIV255_SH +: 8];

    // stage 3 -> 4: rounded numerators, pre-divided by 256
    assign w_zq = 28'(r_it[3].v) * 28'(20'(FRAC_ONE) - r3_sr) + 28'(FRAC_HALF);
    assign w_zt = 28'(r_it[3].v) * 28'(20'(FRAC_ONE) - r3_st) + 28'(FRAC_HALF);

    // stage 4 -> 5: quotient estimates by 3825
    assign w_qprod = 32'(r4_xq) * 32'(LVL_DIV_MUL);
    assign w_tprod = 32'(r4_xt) * 32'(LVL_DIV_MUL);

    // stage 5 -> 6: one correction step, then sector routing
    assign w_remq = r5_xq - 20'(r5_q0) * 20'(LVL_DIV);
    assign w_remt = r5_xt - 20'(r5_t0) * 20'(LVL_DIV);
    assign w_q    = r5_q0 + 8'(w_remq >= 20'(LVL_DIV));
    assign w_t    = r5_t0 + 8'(w_remt >= 20'(LVL_DIV));

    always_comb begin
        if (r_it[5].s == 8'd0) begin
            n_lvl = {N_CH{r_it[5].v}};
        end else begin
            case (r5_sec)
                SEC_R_TO_Y: n_lvl = {r5_p, w_t, r_it[5].v};
                SEC_Y_TO_G: n_lvl = {r5_p, r_it[5].v, w_q};
                SEC_G_TO_C: n_lvl = {w_t, r_it[5].v, r5_p};
                SEC_C_TO_B: n_lvl = {r_it[5].v, w_q, r5_p};
                SEC_B_TO_M: n_lvl = {r_it[5].v, r5_p, w_t};
                default:    n_lvl = {w_q, r5_p, r_it[5].v};
            endcase
        end
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_it[0].wr   <= (i_in.operation == OP_LOAD);
            r_it[0].ch   <= i_in.table_channel;
            r_it[0].tidx <= i_in.table_index;
            r_it[0].ent  <= i_in.table_entry;
            r_it[0].s    <= i_in.saturation;
            r_it[0].v    <= i_in.brightness;
            r0_hue       <= i_in.hue;
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_it[k] <= r_it[k-1];
            end
        end
        if (w_en[1]) begin
            r1_hm <= n_hm;
        end
        if (w_en[2]) begin
            r2_sec <= n_sec;
            r2_rem <= n_rem;
            r2_pn  <= n_pn;
        end
        if (w_en[3]) begin
            r3_sec <= r2_sec;
            r3_sr  <= n_sr;
            r3_st  <= n_st;
            r3_p   <= n_p;
        end
        if (w_en[4]) begin
            r4_sec <= r3_sec;
            r4_p   <= r3_p;
            r4_xq  <= w_zq[27:8];
            r4_xt  <= w_zt[27:8];
        end
        if (w_en[5]) begin
            r5_sec <= r4_sec;
            r5_p   <= r4_p;
            r5_xq  <= r4_xq;
            r5_xt  <= r4_xt;
            r5_q0  <= w_qprod[LVL_DIV_SH +: 8];
            r5_t0  <= w_tprod[LVL_DIV_SH +: 8];
        end
        if (w_en[6]) begin
            r6_lvl <= n_lvl;
        end
    end

    assign o_lvl.valid = r_vld[NST-1];
    assign o_lvl.wr    = r_it[NST-1].wr;
    assign o_lvl.ch    = r_it[NST-1].ch;
    assign o_lvl.tidx  = r_it[NST-1].tidx;
    assign o_lvl.ent   = r_it[NST-1].ent;
    assign o_lvl.lvl   = r6_lvl;

endmodule

/* hw/rtl/hrg_gamma_lane.sv */
module hrg_gamma_lane #(
    parameter int LUT_DEPTH = hrg_pkg::LUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  hrg_pkg::t_lane_ctl i_ctl,
    input  logic [7:0]        i_level,
    input  logic [7:0]        i_tidx,
    input  logic [15:0]       i_ent,
    output logic [15:0]       o_entry
);
    import hrg_pkg::*;

    localparam int IW = $clog2(LUT_DEPTH);
    localparam int WW = 13;

    logic [15:0]   r_mem [LUT_DEPTH];
    logic [15:0]   r_rd;
    logic [IW-1:0] w_map [LEVELS];
    logic [WW-1:0] w_wide;
    logic [IW-1:0] w_waddr;

    // level to table index, rounded
    for (genvar gl = 0; gl < LEVELS; gl++) begin : g_map
        localparam int MAPPED = (gl * (LUT_DEPTH - 1) + LEVEL_MAX / 2) / LEVEL_MAX;
        assign w_map[gl] = IW'(MAPPED);
    end

    assign w_wide  = WW'(i_tidx);
    assign w_waddr = w_wide[IW-1:0];

    // table memory: one write or one read per transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[w_waddr] <= i_ent;
        end
        if (i_ctl.re) begin
            r_rd <= r_mem[w_map[i_level]];
        end
    end

    assign o_entry = r_rd;

endmodule

/* hw/rtl/hsv_to_rgb_gamma.sv */
// HSV to RGB converter with per-channel gamma tables.
//
// i_in carries one item per transfer. A convert item (operation 0) takes
// hue in 1/64 degree, saturation and brightness, and yields one transfer on
// o_out with gamma corrected red, green and blue. A load item (operation 1)
// writes table_entry into the gamma table of table_channel at table_index
// and yields nothing; a bad channel or an index past the table is dropped.
// Items are processed in order, so a load affects every later conversion.
//
// From input transfer to o_out.valid an item passes the input register,
// six arithmetic stages (hue fold, sector and p numerator, products and p,
// numerators, quotient estimate, correction and routing) and the registered
// read of the three gamma memories; one item per cycle unless o_out stalls.
//
// Reset clears the valid bits only; table contents are undefined until
// loaded, and converting a level whose entry was never loaded gives
// undefined data. When o_out stalls, the result holds in the output
// register and the pipeline keeps filling its empty stages; i_in.ready
// drops only when every stage holds an item.
module hsv_to_rgb_gamma #(
    parameter int LUT_DEPTH = hrg_pkg::LUT_DEPTH_DEF,
    parameter int OUT_BITS  = hrg_pkg::OUT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrg_in_if.sink    i_in,
    hrg_out_if.source o_out
);
    import hrg_pkg::*;

    localparam int SH = 16 - OUT_BITS;

    t_lvl                  w_lvl;
    logic                  w_take;
    logic                  w_in_range;
    t_lane_ctl             w_ctl [N_CH];
    logic [N_CH-1:0][15:0] w_ent;
    logic                  r_out_vld;

    // output register frees when empty or taken
    assign w_take = !r_out_vld || o_out.ready;

    hrg_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_lvl   (w_lvl)
    );

    assign w_in_range = (13'(w_lvl.tidx) < 13'(LUT_DEPTH));

    // one gamma memory per channel
    for (genvar gc = 0; gc < N_CH; gc++) begin : g_lane
        assign w_ctl[gc].re = w_take && w_lvl.valid && !w_lvl.wr;
        assign w_ctl[gc].we = w_take && w_lvl.valid && w_lvl.wr && w_in_range &&
                              (w_lvl.ch == 2'(gc));

        hrg_gamma_lane #(
            .LUT_DEPTH (LUT_DEPTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gc]),
            .i_level (w_lvl.lvl[gc]),
            .i_tidx  (w_lvl.tidx),
            .i_ent   (w_lvl.ent),
            .o_entry (w_ent[gc])
        );
    end

    // result valid follows conversions out of the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= w_lvl.valid && !w_lvl.wr;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.red   = 16'(w_ent[CH_RED]   >> SH);
    assign o_out.green = 16'(w_ent[CH_GREEN] >> SH);
    assign o_out.blue  = 16'(w_ent[CH_BLUE]  >> SH);

endmodule

/* hw/rtl/hrg_checker.sv */
module hrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_red,
    input logic [15:0] i_green,
    input logic [15:0] i_blue
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // and keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind hsv_to_rgb_gamma hrg_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue)
);

/* dv/hsv_to_rgb_gamma_test.sv */
module hsv_to_rgb_gamma_test;
    import hrg_pkg::*;

    localparam int         LUT_DEPTH = LUT_DEPTH_DEF;
    localparam int         OUT_BITS  = OUT_BITS_DEF;
    localparam logic [1:0] CH_NONE   = 2'd3;    // no table behind this code
    localparam int         DRAIN_CYC = 24;

    // One input item and one result
    typedef struct packed {
        logic        op;
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic [1:0]  ch;
        logic [7:0]  tidx;
        logic [15:0] ent;
    } t_pixel_cmd;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrg_in_if  in_bus ();
    hrg_out_if out_bus ();

    hsv_to_rgb_gamma DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Pending items, expected colors, our copy of the gamma tables
    t_pixel_cmd  cmd_q [$];
    t_rgb16      rgb_exp_q [$];
    logic [15:0] gamma_lut [N_CH][LUT_DEPTH];

    t_pixel_cmd in_cur;
    bit         in_hold = 1'b0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         n_err = 0;
    int         n_conv = 0;
    int         n_load = 0;
    int         n_drop = 0;
    int         n_checked = 0;

    // Clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Channel level to table entry, scaled to the output width
    function automatic logic [15:0] gamma_read(int ch, int unsigned lvl);
        int unsigned idx;
        idx = (lvl * (LUT_DEPTH - 1) + 127) / 255;
        if (idx >= LUT_DEPTH)
            idx = LUT_DEPTH - 1;
        return gamma_lut[ch][idx] >> (16 - OUT_BITS);
    endfunction

    // HSV to gamma corrected RGB
    function automatic t_rgb16 hsv_convert(t_pixel_cmd c);
        int unsigned hm, rem, s, v, p, q, t, lr, lg, lb;
        logic [2:0]  sec;
        t_rgb16      res;
        hm  = c.hue % HUE_CIRCLE;
        sec = 3'(hm / HUE_SECTOR);
        rem = hm % HUE_SECTOR;
        s   = c.sat;
        v   = c.val;
        p = (v * (LEVEL_MAX - s) + 127) / LEVEL_MAX;
        q = (v * (FRAC_ONE - s * rem) + FRAC_HALF) / FRAC_ONE;
        t = (v * (FRAC_ONE - s * (HUE_SECTOR - rem)) + FRAC_HALF) / FRAC_ONE;
        if (s == 0) begin
            lr = v; lg = v; lb = v;
        end else begin
            case (sec)
                SEC_R_TO_Y: begin lr = v; lg = t; lb = p; end
                SEC_Y_TO_G: begin lr = q; lg = v; lb = p; end
                SEC_G_TO_C: begin lr = p; lg = v; lb = t; end
                SEC_C_TO_B: begin lr = p; lg = q; lb = v; end
                SEC_B_TO_M: begin lr = t; lg = p; lb = v; end
                default:    begin lr = v; lg = p; lb = q; end
            endcase
        end
        res.red   = gamma_read(CH_RED, lr & 8'hFF);
        res.green = gamma_read(CH_GREEN, lg & 8'hFF);
        res.blue  = gamma_read(CH_BLUE, lb & 8'hFF);
        return res;
    endfunction

    // Item builders; unused fields get random values
    function automatic t_pixel_cmd mk_conv(int hue, int sat, int val);
        t_pixel_cmd c;
        c.op   = OP_CONVERT;
        c.hue  = 16'(hue);
        c.sat  = 8'(sat);
        c.val  = 8'(val);
        c.ch   = 2'($urandom_range(3));
        c.tidx = 8'($urandom);
        c.ent  = 16'($urandom);
        return c;
    endfunction

    function automatic t_pixel_cmd mk_load(logic [1:0] ch, int tidx, int ent);
        t_pixel_cmd c;
        c.op   = OP_LOAD;
        c.hue  = 16'($urandom);
        c.sat  = 8'($urandom);
        c.val  = 8'($urandom);
        c.ch   = ch;
        c.tidx = 8'(tidx);
        c.ent  = 16'(ent);
        return c;
    endfunction

    // Fractions with the ends weighted up
    function automatic int rnd_level();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 0;
        if (k == 1)
            return 255;
        return $urandom_range(255);
    endfunction

    // Hue: mostly anywhere, sometimes on or next to a sector edge
    function automatic int rnd_hue();
        int h;
        if ($urandom_range(3) != 0)
            return $urandom_range(65535);
        h = $urandom_range(5) * HUE_SECTOR + $urandom_range(2) * HUE_CIRCLE;
        case ($urandom_range(2))
            0: h = h + 1;
            1: h = h + HUE_SECTOR - 1;
            default: ;
        endcase
        return h;
    endfunction

    // Input driver: new item or idle at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !in_hold) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_cur = cmd_q.pop_front();
                in_hold = 1'b1;
                in_bus.valid         <= 1'b1;
                in_bus.operation     <= in_cur.op;
                in_bus.hue           <= in_cur.hue;
                in_bus.saturation    <= in_cur.sat;
                in_bus.brightness    <= in_cur.val;
                in_bus.table_channel <= in_cur.ch;
                in_bus.table_index   <= in_cur.tidx;
                in_bus.table_entry   <= in_cur.ent;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Input transfer: update tables or queue the expected color
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            if (in_cur.op == OP_LOAD) begin
                if (in_cur.ch != CH_NONE && in_cur.tidx < LUT_DEPTH) begin
                    gamma_lut[in_cur.ch][in_cur.tidx] = in_cur.ent;
                    n_load++;
                end else begin
                    n_drop++;
                end
            end else begin
                rgb_exp_q.push_back(hsv_convert(in_cur));
                n_conv++;
            end
            in_hold = 1'b0;
        end
    end

    // Output side: random back-pressure
    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Output monitor: compare against the oldest expected color
    always @(posedge i_clk) begin
        t_rgb16 got, want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.red   = out_bus.red;
            got.green = out_bus.green;
            got.blue  = out_bus.blue;
            if (rgb_exp_q.size() == 0) begin
                n_err++;
                $display("%0t unexpected output: expected none, got r=%h g=%h b=%h",
                         $time, got.red, got.green, got.blue);
            end else begin
                want = rgb_exp_q.pop_front();
                n_checked++;
                if (got.red !== want.red) begin
                    n_err++;
                    $display("%0t red mismatch: expected %h, got %h",
                             $time, want.red, got.red);
                end
                if (got.green !== want.green) begin
                    n_err++;
                    $display("%0t green mismatch: expected %h, got %h",
                             $time, want.green, got.green);
                end
                if (got.blue !== want.blue) begin
                    n_err++;
                    $display("%0t blue mismatch: expected %h, got %h",
                             $time, want.blue, got.blue);
                end
            end
        end
    end

    // Wait until every item went in and every result came out
    task automatic drain();
        while (cmd_q.size() != 0 || in_hold || rgb_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // One pressure phase of random traffic
    task automatic random_phase(int send_pct, int stall_pct, int n_items);
        int made;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(99) < 15) begin
                cmd_q.push_back(mk_load(2'($urandom_range(3)), $urandom_range(255),
                                        $urandom_range(65535)));
                if (cmd_q[$].ch != CH_NONE)
                    made++;
            end else begin
                cmd_q.push_back(mk_conv(rnd_hue(), rnd_level(), rnd_level()));
                made++;
            end
        end
        drain();
    endtask

    // Stimulus
    initial begin
        in_bus.valid         = 1'b0;
        in_bus.operation     = OP_CONVERT;
        in_bus.hue           = '0;
        in_bus.saturation    = '0;
        in_bus.brightness    = '0;
        in_bus.table_channel = CH_RED;
        in_bus.table_index   = '0;
        in_bus.table_entry   = '0;
        out_bus.ready        = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry before any conversion reads it
        for (int ch = 0; ch < N_CH; ch++) begin
            for (int i = 0; i < LUT_DEPTH; i++) begin
                if (i == 0)
                    cmd_q.push_back(mk_load(2'(ch), i, 16'h0000));
                else if (i == LUT_DEPTH - 1)
                    cmd_q.push_back(mk_load(2'(ch), i, 16'hFFFF));
                else
                    cmd_q.push_back(mk_load(2'(ch), i, $urandom_range(65535)));
            end
        end

        // Directed: field extremes, hue wrap, sector edges, grey, table writes
        cmd_q.push_back(mk_conv(0, 0, 0));
        cmd_q.push_back(mk_conv(0, 255, 255));
        cmd_q.push_back(mk_conv(65535, 255, 255));
        cmd_q.push_back(mk_conv(HUE_CIRCLE - 1, 200, 255));
        cmd_q.push_back(mk_conv(HUE_CIRCLE, 255, 255));
        cmd_q.push_back(mk_conv(HUE_SECTOR - 1, 255, 255));
        for (int k = 0; k < N_SEC; k++) begin
            cmd_q.push_back(mk_conv(k * HUE_SECTOR, 255, 255));
            cmd_q.push_back(mk_conv(k * HUE_SECTOR + HUE_SECTOR / 2, 128, 200));
        end
        cmd_q.push_back(mk_conv(3 * HUE_SECTOR + 77, 0, 173));
        cmd_q.push_back(mk_load(CH_RED, 0, 16'hFFFF));
        cmd_q.push_back(mk_load(CH_NONE, 5, 16'h1234));
        cmd_q.push_back(mk_load(CH_BLUE, 255, 16'h0000));
        cmd_q.push_back(mk_conv(HUE_SECTOR * 4, 255, 0));
        cmd_q.push_back(mk_conv(HUE_SECTOR * 4, 0, 255));
        drain();

        // Random traffic under each pressure setting
        random_phase(0, 0, 250);
        random_phase(69, 0, 250);
        random_phase(0, 69, 250);
        random_phase(12, 12, 250);

        recv_stall_pct = 0;
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("run covered %0d conversions (%0d results checked), %0d table loads,",
                 n_conv, n_checked, n_load);
        $display("%0d dropped loads, under idle, stall and mixed pressure", n_drop);
        if (n_err == 0) begin
            $display("hsv_to_rgb_gamma_test: clean");
        end else begin
            $display("hsv_to_rgb_gamma_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("timeout at %0t", $time);
        $display("hsv_to_rgb_gamma_test: errors");
        $finish;
    end

endmodule

/* hsv_to_rgb_gamma.f */
hw/rtl/hrg_pkg.sv
hw/rtl/hrg_ifs.sv
hw/rtl/hrg_level.sv
hw/rtl/hrg_gamma_lane.sv
hw/rtl/hsv_to_rgb_gamma.sv
hw/rtl/hrg_checker.sv
dv/hsv_to_rgb_gamma_test.sv
